### sv/gs_pkg.sv
// Shared types, constants and fixed-point helpers for the Gray-Scott grid block.
// Used by gs_grid_mem, gs_cell_calc and the top level, not by gs_checker; depends on nothing.
package gs_pkg;

  localparam int GridWidthDefault  = 128;
  localparam int GridHeightDefault = 128;

  localparam int FRAC_BITS = 15;
  localparam int CONC_W    = 16;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int W_EDGE    = (2 * ONE + 5) / 10;
  localparam int W_CORNER  = (ONE + 10) / 20;
  localparam int SUM_W     = CONC_W + 2;
  localparam int WIDE_W    = 48;

  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_ITERATE = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;

  localparam logic [2:0] REG_FEED   = 3'd0;
  localparam logic [2:0] REG_KILL   = 3'd1;
  localparam logic [2:0] REG_DIFF_A = 3'd2;
  localparam logic [2:0] REG_DIFF_B = 3'd3;
  localparam logic [2:0] REG_TSTEP  = 3'd4;

  typedef logic signed [WIDE_W-1:0] gs_wide_t;
  typedef logic [CONC_W-1:0]        gs_conc_t;

  typedef enum logic [1:0] {OFF_ZERO, OFF_MINUS, OFF_PLUS} gs_off_t;

  typedef struct packed {
    gs_conc_t feed;
    gs_conc_t kill;
    gs_conc_t diff_a;
    gs_conc_t diff_b;
    gs_conc_t tstep;
  } gs_cfg_t;

  typedef struct packed {
    gs_conc_t          centre_a;
    gs_conc_t          centre_b;
    logic [SUM_W-1:0]  edge_a;
    logic [SUM_W-1:0]  edge_b;
    logic [SUM_W-1:0]  corner_a;
    logic [SUM_W-1:0]  corner_b;
  } gs_taps_t;

  // round to nearest, ties away from zero, after dropping the fraction bits
  function automatic gs_wide_t fx_round(input gs_wide_t v);
    gs_wide_t half;
    half = gs_wide_t'(1) <<< (FRAC_BITS - 1);
    if (v >= 0) begin
      return (v + half) >>> FRAC_BITS;
    end
    return -((-v + half) >>> FRAC_BITS);
  endfunction

  function automatic gs_conc_t fx_clamp(input gs_wide_t v);
    if (v < 0) begin
      return '0;
    end
    if (v > gs_wide_t'(ONE)) begin
      return CONC_W'(ONE);
    end
    return v[CONC_W-1:0];
  endfunction

  // stencil order: centre first, then the edge neighbours, then the corner neighbours
  function automatic gs_off_t tap_col(input logic [3:0] k);
    case (k)
      4'd1, 4'd5, 4'd7: return OFF_MINUS;
      4'd2, 4'd6, 4'd8: return OFF_PLUS;
      default:          return OFF_ZERO;
    endcase
  endfunction

  function automatic gs_off_t tap_row(input logic [3:0] k);
    case (k)
      4'd3, 4'd5, 4'd8: return OFF_MINUS;
      4'd4, 4'd6, 4'd7: return OFF_PLUS;
      default:          return OFF_ZERO;
    endcase
  endfunction

endpackage

### sv/gs_grid_mem.sv
// Single-port synchronous memory holding both banks of the grid, {A, B} per entry.
// Uses gs_pkg for the concentration width.
module gs_grid_mem
  import gs_pkg::*;
#(
  parameter int DEPTH = 2 * GridWidthDefault * GridHeightDefault,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       addr,
  input  logic [2*CONC_W-1:0] wdata,
  output logic [2*CONC_W-1:0] rdata
);

  logic [2*CONC_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

### sv/gs_cell_calc.sv
// Six-stage datapath computing one cell's new A and B from its stencil sums.
// Uses gs_pkg for structs, weights and rounding helpers.
module gs_cell_calc
  import gs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     go,
  input  gs_cfg_t  cfg,
  input  gs_taps_t taps,
  output logic     done,
  output gs_conc_t new_a,
  output gs_conc_t new_b
);

  logic [5:0] vld;
  gs_wide_t   a, b;
  gs_wide_t   pea, pca, peb, pcb, bb;
  gs_wide_t   lap_a, lap_b, b2, fa_raw, kfb_raw;
  gs_wide_t   tda, tdb, r_raw, fa, kfb;
  gs_wide_t   da, db, r;
  gs_wide_t   pa, pb;

  assign a    = gs_wide_t'(taps.centre_a);
  assign b    = gs_wide_t'(taps.centre_b);
  assign r    = fx_round(r_raw);
  assign done = vld[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], go};
    end
  end

  always_ff @(posedge clk) begin
    pea <= gs_wide_t'(taps.edge_a) * gs_wide_t'(W_EDGE);
    pca <= gs_wide_t'(taps.corner_a) * gs_wide_t'(W_CORNER);
    peb <= gs_wide_t'(taps.edge_b) * gs_wide_t'(W_EDGE);
    pcb <= gs_wide_t'(taps.corner_b) * gs_wide_t'(W_CORNER);
    bb  <= b * b;

    lap_a   <= fx_round(pea + pca - (a <<< FRAC_BITS));
    lap_b   <= fx_round(peb + pcb - (b <<< FRAC_BITS));
    b2      <= fx_round(bb);
    fa_raw  <= gs_wide_t'(cfg.feed) * (gs_wide_t'(ONE) - a);
    kfb_raw <= (gs_wide_t'(cfg.kill) + gs_wide_t'(cfg.feed)) * b;

    tda   <= gs_wide_t'(cfg.diff_a) * lap_a;
    tdb   <= gs_wide_t'(cfg.diff_b) * lap_b;
    r_raw <= a * b2;
    fa    <= fx_round(fa_raw);
    kfb   <= fx_round(kfb_raw);

    da <= fx_round(tda) - r + fa;
    db <= fx_round(tdb) + r - kfb;

    pa <= gs_wide_t'(cfg.tstep) * da;
    pb <= gs_wide_t'(cfg.tstep) * db;

    new_a <= fx_clamp(a + fx_round(pa));
    new_b <= fx_clamp(b + fx_round(pb));
  end

endmodule

### sv/gray_scott_grid_step.sv
// Top level of the Gray-Scott grid: command sequencer, register file and grid memory.
// Depends on gs_pkg, gs_grid_mem and gs_cell_calc.
//
// A toroidal grid of A/B concentrations (unsigned Q1.15) lives in a double-banked
// single-port memory. A write or read command first brings an out-of-range coordinate
// back into range, one wraparound per step; a read result waits in an output
// register while the next command is taken. An iteration reads the nine stencil
// cells of each cell one per cycle through the single memory port, passes the
// sums through a six-stage datapath and writes the result to the other bank,
// cell by cell, with the input stalled throughout; the banks then swap. Every
// cell must be loaded before the first iteration.
module gray_scott_grid_step
  import gs_pkg::*;
#(
  parameter int GRID_WIDTH  = GridWidthDefault,
  parameter int GRID_HEIGHT = GridHeightDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [6:0]  cell_x,
  input  logic [6:0]  cell_y,
  input  logic [15:0] conc_a,
  input  logic [15:0] conc_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] read_a,
  output logic [15:0] read_b
);

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int DEPTH = 2 * CELLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_HEIGHT);
  localparam int MW    = 2 * CONC_W;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_WRAP   = 8'b0000_0010,
    ST_ADDR   = 8'b0000_0100,
    ST_ACCESS = 8'b0000_1000,
    ST_RDATA  = 8'b0001_0000,
    ST_TAP    = 8'b0010_0000,
    ST_CALC   = 8'b0100_0000,
    ST_WRBACK = 8'b1000_0000
  } state_t;

  state_t   state;
  gs_cfg_t  cfg;
  gs_taps_t taps;
  logic     bank;
  logic [1:0]    cmd_mode;
  logic [6:0]    rx, ry;
  gs_conc_t      wr_a, wr_b;
  logic [AW-1:0] req_addr;
  logic [XW-1:0] cx, nx;
  logic [YW-1:0] cy, ny;
  logic [3:0]    tap;
  logic          calc_go, calc_done;
  gs_conc_t      new_a, new_b;
  logic [AW-1:0] mem_addr, tap_addr, wb_addr;
  logic          mem_we;
  logic [MW-1:0] mem_wdata, mem_rdata;
  gs_conc_t      rd_a, rd_b;
  logic          last_x, last_y;
  logic          read_load;

  assign in_stall  = (state != ST_IDLE);
  assign rd_a      = mem_rdata[MW-1:CONC_W];
  assign rd_b      = mem_rdata[CONC_W-1:0];
  assign last_x    = (cx == XW'(GRID_WIDTH - 1));
  assign last_y    = (cy == YW'(GRID_HEIGHT - 1));
  assign read_load = (state == ST_RDATA) && (!out_valid || !out_stall);

  // neighbour coordinates with wraparound
  always_comb begin
    case (tap_col(tap))
      OFF_MINUS: nx = (cx == '0) ? XW'(GRID_WIDTH - 1) : cx - 1'b1;
      OFF_PLUS:  nx = last_x ? '0 : cx + 1'b1;
      default:   nx = cx;
    endcase
    case (tap_row(tap))
      OFF_MINUS: ny = (cy == '0) ? YW'(GRID_HEIGHT - 1) : cy - 1'b1;
      OFF_PLUS:  ny = last_y ? '0 : cy + 1'b1;
      default:   ny = cy;
    endcase
  end

  assign tap_addr = AW'(32'(ny) * GRID_WIDTH + 32'(nx) + (bank ? CELLS : 0));
  assign wb_addr  = AW'(32'(cy) * GRID_WIDTH + 32'(cx) + (bank ? 0 : CELLS));

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = req_addr;
    mem_wdata = {wr_a, wr_b};
    case (state)
      ST_ACCESS: mem_we = (cmd_mode == MODE_WRITE);
      ST_TAP:    mem_addr = tap_addr;
      ST_WRBACK: begin
        mem_we    = 1'b1;
        mem_addr  = wb_addr;
        mem_wdata = {new_a, new_b};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{feed: 16'd983, kill: 16'd1966, diff_a: 16'd32768,
               diff_b: 16'd16384, tstep: 16'd32768};
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FEED:   cfg.feed   <= cfg_data;
        REG_KILL:   cfg.kill   <= cfg_data;
        REG_DIFF_A: cfg.diff_a <= cfg_data;
        REG_DIFF_B: cfg.diff_b <= cfg_data;
        REG_TSTEP:  cfg.tstep  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bank      <= 1'b0;
      out_valid <= 1'b0;
      calc_go   <= 1'b0;
    end else begin
      calc_go <= (state == ST_TAP) && (tap == 4'd9);
      if (read_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_mode <= mode;
            rx       <= cell_x;
            ry       <= cell_y;
            wr_a     <= fx_clamp(gs_wide_t'(conc_a));
            wr_b     <= fx_clamp(gs_wide_t'(conc_b));
            cx       <= '0;
            cy       <= '0;
            tap      <= '0;
            if (mode == MODE_ITERATE) begin
              state <= ST_TAP;
            end else if (mode == MODE_WRITE || mode == MODE_READ) begin
              state <= ST_WRAP;
            end
          end
        end
        ST_WRAP: begin
          // one subtraction a cycle; only grids narrower or shorter than 128 cells ever take it
          if (32'(rx) >= GRID_WIDTH) begin
            rx <= rx - 7'(GRID_WIDTH);
          end else if (32'(ry) >= GRID_HEIGHT) begin
            ry <= ry - 7'(GRID_HEIGHT);
          end else begin
            state <= ST_ADDR;
          end
        end
        ST_ADDR: begin
          req_addr <= AW'(32'(ry) * GRID_WIDTH + 32'(rx) + (bank ? CELLS : 0));
          state    <= ST_ACCESS;
        end
        ST_ACCESS: begin
          state <= (cmd_mode == MODE_READ) ? ST_RDATA : ST_IDLE;
        end
        ST_RDATA: begin
          if (read_load) begin
            read_a <= rd_a;
            read_b <= rd_b;
            state  <= ST_IDLE;
          end
        end
        ST_TAP: begin
          // data of the previous tap arrives while the next is issued
          case (tap)
            4'd0: begin
              taps.edge_a   <= '0;
              taps.edge_b   <= '0;
              taps.corner_a <= '0;
              taps.corner_b <= '0;
            end
            4'd1: begin
              taps.centre_a <= rd_a;
              taps.centre_b <= rd_b;
            end
            4'd2, 4'd3, 4'd4, 4'd5: begin
              taps.edge_a <= taps.edge_a + SUM_W'(rd_a);
              taps.edge_b <= taps.edge_b + SUM_W'(rd_b);
            end
            default: begin
              taps.corner_a <= taps.corner_a + SUM_W'(rd_a);
              taps.corner_b <= taps.corner_b + SUM_W'(rd_b);
            end
          endcase
          if (tap == 4'd9) begin
            state <= ST_CALC;
          end else begin
            tap <= tap + 1'b1;
          end
        end
        ST_CALC: begin
          if (calc_done) begin
            state <= ST_WRBACK;
          end
        end
        ST_WRBACK: begin
          tap <= '0;
          if (last_x) begin
            cx <= '0;
            if (last_y) begin
              bank  <= ~bank;
              state <= ST_IDLE;
            end else begin
              cy    <= cy + 1'b1;
              state <= ST_TAP;
            end
          end else begin
            cx    <= cx + 1'b1;
            state <= ST_TAP;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  gs_grid_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  gs_cell_calc u_calc (
    .clk  (clk),
    .rst  (rst),
    .go   (calc_go),
    .cfg  (cfg),
    .taps (taps),
    .done (calc_done),
    .new_a(new_a),
    .new_b(new_b)
  );

endmodule

### sv/gs_checker.sv
// Port-level checks on the Gray-Scott grid block, bound to the top level.
// Depends on gray_scott_grid_step only through its ports.
module gs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] read_a,
  input logic [15:0] read_b
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_a) && $stable(read_b))
    else $error("stalled result changed or dropped");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> read_a <= 16'd32768 && read_b <= 16'd32768)
    else $error("result concentration above one");

  a_rise_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a command in progress");

  a_rise_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("block still busy after delivering a read");

endmodule

bind gray_scott_grid_step gs_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .read_a   (read_a),
  .read_b   (read_b)
);

### bench/gray_scott_grid_step_test.sv
// Testbench for gray_scott_grid_step: loads the grid, reads cells back and runs
// iterations, checking every read against a scoreboard that holds its own copy of the grid.
// Depends on gs_pkg and the gray_scott_grid_step RTL.
`timescale 1ns / 100ps

module gray_scott_grid_step_test;
  import gs_pkg::*;

  localparam int CellCount  = 128 * 128;
  localparam int CycleLimit = 4000000;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [2:0] REG_SPARE  = 3'd5;

  class grid_scoreboard;
    int unsigned  conc_a_bank[2][CellCount];
    int unsigned  conc_b_bank[2][CellCount];
    bit           bank_sel;
    longint       feed, kill, diff_a, diff_b, tstep;
    logic [15:0]  pending_a[$];
    logic [15:0]  pending_b[$];
    int           errors;

    function new();
      bank_sel = 0;
      feed = 983;
      kill = 1966;
      diff_a = 32768;
      diff_b = 16384;
      tstep = 32768;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_FEED:   feed = val;
        REG_KILL:   kill = val;
        REG_DIFF_A: diff_a = val;
        REG_DIFF_B: diff_b = val;
        REG_TSTEP:  tstep = val;
        default: ;
      endcase
    endfunction

    function longint round_q(longint v);
      longint half;
      half = longint'(1) << (FRAC_BITS - 1);
      if (v >= 0) return (v + half) >>> FRAC_BITS;
      return -((-v + half) >>> FRAC_BITS);
    endfunction

    function longint clamp_unit(longint v);
      if (v < 0) return 0;
      if (v > ONE) return ONE;
      return v;
    endfunction

    function longint stencil(bit is_b, int x, int y);
      int xl, xr, yu, yd;
      longint edges, corners, sum;
      xl = (x + 127) % 128;
      xr = (x + 1) % 128;
      yu = (y + 127) % 128;
      yd = (y + 1) % 128;
      if (is_b) begin
        edges = conc_b_bank[bank_sel][xl + y*128] + conc_b_bank[bank_sel][xr + y*128]
              + conc_b_bank[bank_sel][x + yu*128] + conc_b_bank[bank_sel][x + yd*128];
        corners = conc_b_bank[bank_sel][xl + yu*128] + conc_b_bank[bank_sel][xr + yd*128]
                + conc_b_bank[bank_sel][xl + yd*128] + conc_b_bank[bank_sel][xr + yu*128];
        sum = W_EDGE*edges + W_CORNER*corners - ONE*longint'(conc_b_bank[bank_sel][x + y*128]);
      end else begin
        edges = conc_a_bank[bank_sel][xl + y*128] + conc_a_bank[bank_sel][xr + y*128]
              + conc_a_bank[bank_sel][x + yu*128] + conc_a_bank[bank_sel][x + yd*128];
        corners = conc_a_bank[bank_sel][xl + yu*128] + conc_a_bank[bank_sel][xr + yd*128]
                + conc_a_bank[bank_sel][xl + yd*128] + conc_a_bank[bank_sel][xr + yu*128];
        sum = W_EDGE*edges + W_CORNER*corners - ONE*longint'(conc_a_bank[bank_sel][x + y*128]);
      end
      return round_q(sum);
    endfunction

    function void iterate_grid();
      int i;
      longint a, b, la, lb, react, da, db;
      for (int y = 0; y < 128; y++) begin
        for (int x = 0; x < 128; x++) begin
          i = x + y*128;
          a = conc_a_bank[bank_sel][i];
          b = conc_b_bank[bank_sel][i];
          la = stencil(0, x, y);
          lb = stencil(1, x, y);
          react = round_q(a * round_q(b * b));
          da = round_q(diff_a * la) - react + round_q(feed * (ONE - a));
          db = round_q(diff_b * lb) + react - round_q((kill + feed) * b);
          conc_a_bank[!bank_sel][i] = int'(clamp_unit(a + round_q(tstep * da)));
          conc_b_bank[!bank_sel][i] = int'(clamp_unit(b + round_q(tstep * db)));
        end
      end
      bank_sel = !bank_sel;
    endfunction

    // one accepted command transfer
    function void note_command(logic [1:0] md, logic [6:0] x, logic [6:0] y,
                               logic [15:0] ca, logic [15:0] cb);
      int i;
      i = int'(x) + int'(y)*128;
      case (md)
        MODE_WRITE: begin
          conc_a_bank[bank_sel][i] = int'(clamp_unit(ca));
          conc_b_bank[bank_sel][i] = int'(clamp_unit(cb));
        end
        MODE_ITERATE: iterate_grid();
        MODE_READ: begin
          pending_a.push_back(conc_a_bank[bank_sel][i][15:0]);
          pending_b.push_back(conc_b_bank[bank_sel][i][15:0]);
        end
        default: ;
      endcase
    endfunction

    function void check_read(logic [15:0] ra, logic [15:0] rb);
      logic [15:0] ea, eb;
      if (pending_a.size() == 0) begin
        $error("unexpected read result a=%0d b=%0d", ra, rb);
        errors++;
        return;
      end
      ea = pending_a.pop_front();
      eb = pending_b.pop_front();
      if (ra !== ea) begin
        $error("read_a: expected %0d, got %0d", ea, ra);
        errors++;
      end
      if (rb !== eb) begin
        $error("read_b: expected %0d, got %0d", eb, rb);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  mode;
  logic [6:0]  cell_x;
  logic [6:0]  cell_y;
  logic [15:0] conc_a;
  logic [15:0] conc_b;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] read_a;
  logic [15:0] read_b;

  grid_scoreboard board;
  int  cycles = 0;
  bit  hold_req;
  int  idle_max;

  gray_scott_grid_step u_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .cell_x(cell_x), .cell_y(cell_y), .conc_a(conc_a), .conc_b(conc_b),
    .out_valid(out_valid), .out_stall(out_stall), .read_a(read_a), .read_b(read_b)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("gray_scott_grid_step_test NOT OK");
      $finish;
    end
  end

  // result side: random stall per transfer, plus one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    bit next_stall;
    stall_left = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_valid && !out_stall) begin
          board.check_read(read_a, read_b);
          stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        end
        if (hold_req) begin
          hold_req = 0;
          hold_left = 400;
        end
        next_stall = (hold_left > 0) || (stall_left > 0);
        if (hold_left > 0) hold_left--;
        else if (stall_left > 0) stall_left--;
        out_stall <= next_stall;
      end
    end
  end

  // one write cycle, then cfg_write low again before returning
  task automatic set_reg(logic [2:0] idx, logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic send(logic [1:0] md, logic [6:0] x, logic [6:0] y,
                      logic [15:0] ca, logic [15:0] cb);
    int gap;
    gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= md;
    cell_x   <= x;
    cell_y   <= y;
    conc_a   <= ca;
    conc_b   <= cb;
    do @(posedge clk); while (in_stall);
    board.note_command(md, x, y, ca, cb);
  endtask

  function automatic logic [15:0] rand_conc();
    if ($urandom_range(0, 7) == 0) return 16'($urandom());
    return 16'($urandom_range(0, ONE));
  endfunction

  task automatic read_rand();
    send(MODE_READ, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), 16'($urandom()),
         16'($urandom()));
  endtask

  // drain results before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_a.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    int r;
    board = new();
    hold_req = 0;
    idle_max = 7;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    mode = MODE_WRITE;
    cell_x = '0;
    cell_y = '0;
    conc_a = '0;
    conc_b = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners of the grid, saturation above one
    send(MODE_WRITE, 7'd0, 7'd0, 16'd0, 16'd32768);
    send(MODE_WRITE, 7'd127, 7'd127, 16'hFFFF, 16'd0);
    send(MODE_WRITE, 7'd127, 7'd0, 16'd32769, 16'hFFFF);
    send(MODE_WRITE, 7'd0, 7'd127, 16'd32768, 16'd1);
    send(MODE_READ, 7'd0, 7'd0, 16'd0, 16'd0);
    send(MODE_READ, 7'd127, 7'd127, 16'hFFFF, 16'hFFFF);
    send(MODE_SPARE, 7'd127, 7'd0, 16'hFFFF, 16'hFFFF);
    send(MODE_READ, 7'd127, 7'd0, 16'd0, 16'd0);
    send(MODE_READ, 7'd0, 7'd127, 16'd0, 16'd0);
    send(MODE_SPARE, 7'd0, 7'd0, 16'd0, 16'd0);
    send(MODE_READ, 7'd0, 7'd0, 16'd0, 16'd0);

    // load every cell; short gaps keep the sweep quick
    idle_max = 2;
    for (int y = 0; y < 128; y++)
      for (int x = 0; x < 128; x++)
        send(MODE_WRITE, 7'(x), 7'(y), rand_conc(), rand_conc());
    idle_max = 7;

    // long receiver hold-off while reads keep coming
    hold_req = 1;
    repeat (30) read_rand();

    for (int n = 0; n < 70; n++) begin
      r = $urandom_range(0, 9);
      if (r < 4) send(MODE_WRITE, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                      rand_conc(), rand_conc());
      else if (r < 9) read_rand();
      else send(MODE_SPARE, 7'($urandom()), 7'($urandom()), 16'($urandom()), 16'($urandom()));
    end
    settle();

    // extreme register settings, one ignored index
    set_reg(REG_FEED, 16'd32768);
    set_reg(REG_KILL, 16'd0);
    set_reg(REG_DIFF_A, 16'd0);
    set_reg(REG_DIFF_B, 16'hFFFF);
    set_reg(REG_TSTEP, 16'd32768);
    set_reg(REG_SPARE, 16'd0);
    send(MODE_ITERATE, 7'($urandom()), 7'($urandom()), 16'($urandom()), 16'($urandom()));
    repeat (25) read_rand();
    settle();

    set_reg(REG_FEED, 16'($urandom_range(0, 4000)));
    set_reg(REG_KILL, 16'($urandom_range(0, 4000)));
    set_reg(REG_DIFF_A, 16'($urandom_range(0, ONE)));
    set_reg(REG_DIFF_B, 16'($urandom_range(0, ONE)));
    set_reg(REG_TSTEP, 16'($urandom_range(0, ONE)));
    send(MODE_ITERATE, 7'd0, 7'd0, 16'd0, 16'd0);
    for (int n = 0; n < 25; n++) begin
      if ($urandom_range(0, 3) == 0)
        send(MODE_WRITE, 7'($urandom()), 7'($urandom()), rand_conc(), rand_conc());
      else
        read_rand();
    end
    settle();

    if (board.errors == 0 && board.pending_a.size() == 0) begin
      $display("gray_scott_grid_step_test OK");
    end else begin
      $display("gray_scott_grid_step_test NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
sv/gs_pkg.sv
sv/gs_grid_mem.sv
sv/gs_cell_calc.sv
sv/gray_scott_grid_step.sv
sv/gs_checker.sv
bench/gray_scott_grid_step_test.sv
